// ----- rtl/dual_seed_lookup2_hash_assert.svh -----
// Assertion macros used by the checker file of the lookup2 hash block.
`ifndef DUAL_SEED_LOOKUP2_HASH_ASSERT_SVH
`define DUAL_SEED_LOOKUP2_HASH_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define DSL2H_ASSERT_NOW(lbl, ck, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define DSL2H_ASSERT_NEXT(lbl, ck, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/dsl2h_pkg.sv -----
// Types, constants and mixing functions of the dual-seed lookup2 hash block.
package dsl2h_pkg;

	localparam logic [31:0] GOLDEN          = 32'h9e3779b9;
	localparam logic [31:0] SEED_HIGH_RESET = 32'd0;
	localparam logic [31:0] SEED_LOW_RESET  = 32'd102072;

	localparam int unsigned LANES       = 2;
	localparam int unsigned LANE_HIGH   = 0;
	localparam int unsigned LANE_LOW    = 1;
	localparam int unsigned BLOCK_BYTES = 12;
	localparam int unsigned FILL_W      = 4;
	localparam int unsigned MIX_STEPS   = 9;
	localparam int unsigned STEP_W      = 4;

	localparam int unsigned CFG_INDEX_W = 1;
	localparam logic [CFG_INDEX_W-1:0] REG_SEED_HIGH = 1'b0;
	localparam logic [CFG_INDEX_W-1:0] REG_SEED_LOW  = 1'b1;

	typedef struct packed {
		logic [31:0] a;
		logic [31:0] b;
		logic [31:0] c;
	} lane_t;

	typedef lane_t [LANES-1:0] lanes_t;

	// One unit of work for the mixing pipelines.
	typedef struct packed {
		logic                    blk;    // a full block is mixed
		logic                    fin;    // the message ends here
		logic                    prior;  // an earlier block of this message was mixed
		logic [LANES-1:0][31:0]  seed;   // seeds latched at the message start
		lane_t                   blkw;   // little-endian block words
		lane_t                   tail;   // tail words, low byte of c kept clear
		logic [31:0]             len;    // message length so far
	} job_t;

	function automatic lane_t lane_init(input logic [31:0] seed);
		lane_t r;
		r.a = GOLDEN;
		r.b = GOLDEN;
		r.c = seed;
		return r;
	endfunction

	// One line of the mix: one word takes two subtractions and a shifted xor.
	function automatic lane_t mix_line(input lane_t w, input logic [STEP_W-1:0] step);
		lane_t r;
		r = w;
		case (step)
			4'd0: r.a = (w.a - w.b - w.c) ^ (w.c >> 13);
			4'd1: r.b = (w.b - w.c - w.a) ^ (w.a << 8);
			4'd2: r.c = (w.c - w.a - w.b) ^ (w.b >> 13);
			4'd3: r.a = (w.a - w.b - w.c) ^ (w.c >> 12);
			4'd4: r.b = (w.b - w.c - w.a) ^ (w.a << 16);
			4'd5: r.c = (w.c - w.a - w.b) ^ (w.b >> 5);
			4'd6: r.a = (w.a - w.b - w.c) ^ (w.c >> 3);
			4'd7: r.b = (w.b - w.c - w.a) ^ (w.a << 10);
			4'd8: r.c = (w.c - w.a - w.b) ^ (w.b >> 15);
			default: r = w;
		endcase
		return r;
	endfunction

endpackage

// ----- rtl/dsl2h_front.sv -----
// Seed registers, byte gathering and job issue of the lookup2 hash block.
module dsl2h_front (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_write,
	input  logic [dsl2h_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  logic [31:0]                        cfg_data,
	input  logic                               take,
	input  logic                               en,
	input  logic [7:0]                         data_byte,
	input  logic                               has_byte,
	input  logic                               last,
	output logic                               job_vld_s1,
	output dsl2h_pkg::job_t                    job_s1
);
	import dsl2h_pkg::*;

	logic [31:0]                       seed_high_q;
	logic [31:0]                       seed_low_q;
	logic                              busy_q;
	logic [FILL_W-1:0]                 fill_q;
	logic [31:0]                       len_q;
	logic                              had_q;
	logic [LANES-1:0][31:0]            seed_q;
	logic [BLOCK_BYTES-1:0][7:0]       bytes_q;

	logic                              act;
	logic                              start;
	logic                              blk;
	logic [FILL_W-1:0]                 cur_fill;
	logic [FILL_W-1:0]                 fill_nx;
	logic [31:0]                       cur_len;
	logic [31:0]                       len_nx;
	logic                              cur_prior;
	logic [LANES-1:0][31:0]            cur_seed;
	logic [BLOCK_BYTES-1:0][7:0]       cur_bytes;
	logic [BLOCK_BYTES-1:0][7:0]       wr_bytes;
	logic [BLOCK_BYTES-1:0][7:0]       nx_bytes;
	job_t                              job;
	logic                              job_vld;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_high_q <= SEED_HIGH_RESET;
			seed_low_q  <= SEED_LOW_RESET;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_SEED_HIGH: seed_high_q <= cfg_data;
				REG_SEED_LOW:  seed_low_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		act       = take && (has_byte || last);
		start     = !busy_q;
		cur_fill  = start ? '0 : fill_q;
		cur_len   = start ? '0 : len_q;
		cur_prior = start ? 1'b0 : had_q;
		cur_seed[LANE_HIGH] = start ? seed_high_q : seed_q[LANE_HIGH];
		cur_seed[LANE_LOW]  = start ? seed_low_q  : seed_q[LANE_LOW];
		cur_bytes = start ? '0 : bytes_q;
		for (int k = 0; k < BLOCK_BYTES; k++) begin
			wr_bytes[k] = (has_byte && cur_fill == FILL_W'(k)) ? data_byte : cur_bytes[k];
		end
		blk      = has_byte && (cur_fill == FILL_W'(BLOCK_BYTES - 1));
		fill_nx  = blk ? '0 : (has_byte ? cur_fill + 1'b1 : cur_fill);
		len_nx   = has_byte ? cur_len + 32'd1 : cur_len;
		nx_bytes = blk ? '0 : wr_bytes;

		job.blk    = blk;
		job.fin    = last;
		job.prior  = cur_prior;
		job.seed   = cur_seed;
		job.blkw.a = {wr_bytes[3], wr_bytes[2], wr_bytes[1], wr_bytes[0]};
		job.blkw.b = {wr_bytes[7], wr_bytes[6], wr_bytes[5], wr_bytes[4]};
		job.blkw.c = {wr_bytes[11], wr_bytes[10], wr_bytes[9], wr_bytes[8]};
		job.tail.a = {nx_bytes[3], nx_bytes[2], nx_bytes[1], nx_bytes[0]};
		job.tail.b = {nx_bytes[7], nx_bytes[6], nx_bytes[5], nx_bytes[4]};
		job.tail.c = {nx_bytes[10], nx_bytes[9], nx_bytes[8], 8'h00};
		job.len    = len_nx;
		job_vld    = act && (blk || last);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			fill_q <= '0;
			len_q  <= '0;
			had_q  <= 1'b0;
		end else if (act) begin
			busy_q <= !last;
			fill_q <= fill_nx;
			len_q  <= len_nx;
			had_q  <= cur_prior || blk;
		end
	end

	always_ff @(posedge clk) begin
		if (act) begin
			seed_q  <= cur_seed;
			bytes_q <= nx_bytes;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			job_vld_s1 <= 1'b0;
		end else if (en) begin
			job_vld_s1 <= job_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			job_s1 <= job;
		end
	end

endmodule

// ----- rtl/dsl2h_mix.sv -----
// Nine-stage pipelined lookup2 mix for both lanes, one mix line per stage.
module dsl2h_mix (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_valid,
	input  dsl2h_pkg::lanes_t in_words,
	output logic              out_valid,
	output dsl2h_pkg::lanes_t out_words
);
	import dsl2h_pkg::*;

	logic [MIX_STEPS-1:0] vld_s;
	lanes_t               wrd_s [MIX_STEPS];
	lanes_t               src   [MIX_STEPS];
	lanes_t               nxt   [MIX_STEPS];

	always_comb begin
		src[0] = in_words;
		for (int i = 1; i < MIX_STEPS; i++) begin
			src[i] = wrd_s[i-1];
		end
		for (int i = 0; i < MIX_STEPS; i++) begin
			for (int l = 0; l < LANES; l++) begin
				nxt[i][l] = mix_line(src[i][l], STEP_W'(i));
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[MIX_STEPS-2:0], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < MIX_STEPS; i++) begin
				wrd_s[i] <= nxt[i];
			end
		end
	end

	assign out_valid = vld_s[MIX_STEPS-1];
	assign out_words = wrd_s[MIX_STEPS-1];

endmodule

// ----- rtl/dual_seed_lookup2_hash.sv -----
// Top level of the dual-seed lookup2 hash block.
//
// The block hashes a byte stream with two lookup2 lanes that differ only in
// their seed. The item channel (item_valid / item_stall) carries one beat per
// byte; has_byte marks a real byte and last closes the message, so a beat with
// last and no byte finishes the message, or hashes the empty message. Each
// message gives one beat on the result channel (result_valid / result_stall)
// with hash_high and hash_low.
// Seeds are written through cfg_write / cfg_index / cfg_data and are latched
// at the first beat of a message, so a write affects the next message only.
// One item beat is taken every cycle while item_stall is low. After the
// beat carrying last, a result passes through an issue register, a block
// add stage, the nine-stage block mix, a finishing add stage, the
// nine-stage final mix and the result register. A block mix result returns
// to the lane accumulator before the next block of the same message, twelve
// beats on, can reach the add stage.
// Reset restores the seed reset values and leaves no message in progress and
// no result pending.
// While the receiver stalls, the result register holds its beat and the
// pipeline keeps taking items; only when a second result reaches the end of
// the final mix does the whole pipeline halt, and item_stall rises with it.
module dual_seed_lookup2_hash (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_write,
	input  logic [dsl2h_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  logic [31:0]                        cfg_data,
	input  logic                               item_valid,
	output logic                               item_stall,
	input  logic [7:0]                         data_byte,
	input  logic                               has_byte,
	input  logic                               last,
	output logic                               result_valid,
	input  logic                               result_stall,
	output logic [31:0]                        hash_high,
	output logic [31:0]                        hash_low
);
	import dsl2h_pkg::*;

	// Global advance: everything moves together, so the spacing between jobs
	// that the accumulator relies on is kept through a halt.
	logic   en;
	logic   take;

	logic   job_vld_s1;
	job_t   job_s1;

	logic   vld_s2;
	lanes_t words_s2;
	lanes_t add_w;

	// Job fields travel beside the add stage and the block mix in their own
	// delay line, one entry per register the words pass through.
	job_t   job_d [MIX_STEPS+1];
	job_t   bm_job;
	logic   bm_valid;
	lanes_t bm_words;

	// Accumulator: lane words after the latest block mix of the message.
	lanes_t acc_q;

	lanes_t fin_w;
	logic   vld_s3;
	lanes_t words_s3;

	logic   fo_valid;
	lanes_t fo_words;

	logic        res_valid_q;
	logic [31:0] hash_high_q;
	logic [31:0] hash_low_q;

	assign en         = !(res_valid_q && result_stall && fo_valid);
	assign item_stall = !en;
	assign take       = item_valid && en;

	dsl2h_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_write  (cfg_write),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.take       (take),
		.en         (en),
		.data_byte  (data_byte),
		.has_byte   (has_byte),
		.last       (last),
		.job_vld_s1 (job_vld_s1),
		.job_s1     (job_s1)
	);

	// Block words are added onto the accumulator, or onto the initial words
	// when this is the first block of the message.
	always_comb begin
		lane_t base;
		for (int l = 0; l < LANES; l++) begin
			base       = job_s1.prior ? acc_q[l] : lane_init(job_s1.seed[l]);
			add_w[l].a = base.a + job_s1.blkw.a;
			add_w[l].b = base.b + job_s1.blkw.b;
			add_w[l].c = base.c + job_s1.blkw.c;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s2 <= job_vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			words_s2 <= add_w;
			job_d[0] <= job_s1;
			for (int i = 1; i < MIX_STEPS + 1; i++) begin
				job_d[i] <= job_d[i-1];
			end
		end
	end

	dsl2h_mix u_mix_blk (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (vld_s2),
		.in_words  (words_s2),
		.out_valid (bm_valid),
		.out_words (bm_words)
	);

	assign bm_job = job_d[MIX_STEPS];

	always_ff @(posedge clk) begin
		if (en && bm_valid && bm_job.blk) begin
			acc_q <= bm_words;
		end
	end

	// Finishing: start from this beat's own block result, else from the
	// accumulator, else from the initial words, then add length and tail.
	always_comb begin
		lane_t fb;
		for (int l = 0; l < LANES; l++) begin
			if (bm_job.blk) begin
				fb = bm_words[l];
			end else if (bm_job.prior) begin
				fb = acc_q[l];
			end else begin
				fb = lane_init(bm_job.seed[l]);
			end
			fin_w[l].a = fb.a + bm_job.tail.a;
			fin_w[l].b = fb.b + bm_job.tail.b;
			fin_w[l].c = fb.c + bm_job.len + bm_job.tail.c;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s3 <= bm_valid && bm_job.fin;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			words_s3 <= fin_w;
		end
	end

	dsl2h_mix u_mix_fin (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (vld_s3),
		.in_words  (words_s3),
		.out_valid (fo_valid),
		.out_words (fo_words)
	);

	// Result register: loads whenever it is empty or its beat is being taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (!res_valid_q || !result_stall) begin
			res_valid_q <= fo_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!res_valid_q || !result_stall) begin
			hash_high_q <= fo_words[LANE_HIGH].c;
			hash_low_q  <= fo_words[LANE_LOW].c;
		end
	end

	assign result_valid = res_valid_q;
	assign hash_high    = hash_high_q;
	assign hash_low     = hash_low_q;

endmodule

// ----- rtl/dsl2h_checker.sv -----
// Port-level checker of the lookup2 hash block and its bind to the top level.
`include "dual_seed_lookup2_hash_assert.svh"

module dsl2h_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        item_stall,
	input logic        result_valid,
	input logic        result_stall,
	input logic [31:0] hash_high,
	input logic [31:0] hash_low
);

	// A stalled result beat stays and keeps its payload.
	`DSL2H_ASSERT_NEXT(a_result_hold, clk, arst_n, result_valid && result_stall, result_valid && $stable(hash_high) && $stable(hash_low), "stalled result beat changed")

	// Intake halts only behind a result that the receiver is holding back.
	`DSL2H_ASSERT_NOW(a_stall_cause, clk, arst_n, item_stall, result_valid && result_stall, "item stall without a stalled result")

	// No result beat is pending straight after reset.
	`DSL2H_ASSERT_NOW(a_reset_clean, clk, arst_n, $rose(arst_n), !result_valid, "result beat present after reset")

endmodule

bind dual_seed_lookup2_hash dsl2h_checker u_dsl2h_checker (.*);

// ----- sim/tb_top.sv -----
// Self-checking testbench of the dual-seed lookup2 hash block.
`timescale 1ns / 1ps

module tb_top;
	import dsl2h_pkg::*;

	// Cycles without any accepted beat or register write before the run is
	// declared hung. The slowest correct stretch is a long sender gap, the
	// pipeline and a long receiver stall, so this is many times that.
	localparam int unsigned WATCHDOG_LIMIT = 5000;
	// Quiet cycles allowed after the last result before a register write or
	// the end of the run; comfortably above the pipeline latency.
	localparam int unsigned SETTLE_CYCLES  = 30;

	// One beat on the item channel.
	typedef struct packed {
		logic [7:0] data;
		logic       has;
		logic       fin;
	} byte_beat_t;

	// Both lane hashes of one message.
	typedef struct packed {
		logic [31:0] high;
		logic [31:0] low;
	} digest_t;

	logic        clk          = 1'b0;
	logic        arst_n       = 1'b0;
	logic        cfg_write    = 1'b0;
	logic [CFG_INDEX_W-1:0] cfg_index = REG_SEED_HIGH;
	logic [31:0] cfg_data     = 32'd0;
	logic        item_valid   = 1'b0;
	logic        item_stall;
	logic [7:0]  data_byte    = 8'd0;
	logic        has_byte     = 1'b0;
	logic        last         = 1'b0;
	logic        result_valid;
	logic        result_stall = 1'b0;
	logic [31:0] hash_high;
	logic [31:0] hash_low;

	dual_seed_lookup2_hash dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_write    (cfg_write),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.data_byte    (data_byte),
		.has_byte     (has_byte),
		.last         (last),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.hash_high    (hash_high),
		.hash_low     (hash_low)
	);

	always #5 clk = ~clk;

	// Beats waiting to be driven, and the digests that accepted beats imply.
	byte_beat_t byte_beats[$];
	digest_t    digest_queue[$];
	int unsigned mismatches = 0;

	// Predictor state: the seed registers as last written, and the message
	// in progress with its two lanes, the partial block and the byte count.
	logic [31:0] seed_high_reg = SEED_HIGH_RESET;
	logic [31:0] seed_low_reg  = SEED_LOW_RESET;
	lane_t       lane_words[LANES];
	logic [7:0]  block_buf[BLOCK_BYTES];
	int unsigned block_count = 0;
	logic [31:0] byte_count  = 32'd0;
	bit          in_message  = 1'b0;

	task automatic note_mismatch(input string msg);
		$display("mismatch at %0t ns: %s", $time, msg);
		mismatches++;
	endtask

	// The lookup2 mix, written out as nine lines of subtract and shifted xor.
	function automatic lane_t churn(input lane_t w);
		logic [31:0] a;
		logic [31:0] b;
		logic [31:0] c;
		a = w.a;
		b = w.b;
		c = w.c;
		a = (a - b - c) ^ (c >> 13);
		b = (b - c - a) ^ (a << 8);
		c = (c - a - b) ^ (b >> 13);
		a = (a - b - c) ^ (c >> 12);
		b = (b - c - a) ^ (a << 16);
		c = (c - a - b) ^ (b >> 5);
		a = (a - b - c) ^ (c >> 3);
		b = (b - c - a) ^ (a << 10);
		c = (c - a - b) ^ (b >> 15);
		return '{a: a, b: b, c: c};
	endfunction

	function automatic logic [31:0] block_word(input int unsigned base);
		return {block_buf[base+3], block_buf[base+2], block_buf[base+1], block_buf[base]};
	endfunction

	// Advances the predictor by one accepted item beat. A message finishes
	// on the beat carrying last, and its digest joins the expected queue.
	task automatic absorb_beat(input byte_beat_t bt);
		lane_t blk;
		lane_t tail;
		if (!bt.has && !bt.fin)
			return;
		// The seeds are taken up on the first beat of each message only.
		if (!in_message) begin
			lane_words[LANE_HIGH] = '{a: GOLDEN, b: GOLDEN, c: seed_high_reg};
			lane_words[LANE_LOW]  = '{a: GOLDEN, b: GOLDEN, c: seed_low_reg};
			foreach (block_buf[i])
				block_buf[i] = 8'd0;
			block_count = 0;
			byte_count  = 32'd0;
			in_message  = 1'b1;
		end
		if (bt.has) begin
			block_buf[block_count] = bt.data;
			block_count++;
			byte_count++;
			if (block_count == BLOCK_BYTES) begin
				blk = '{a: block_word(0), b: block_word(4), c: block_word(8)};
				for (int k = 0; k < LANES; k++) begin
					lane_words[k].a += blk.a;
					lane_words[k].b += blk.b;
					lane_words[k].c += blk.c;
					lane_words[k] = churn(lane_words[k]);
				end
				foreach (block_buf[i])
					block_buf[i] = 8'd0;
				block_count = 0;
			end
		end
		if (bt.fin) begin
			// Unfilled tail bytes are zero, so whole words may be added; the
			// low byte of the third word is reserved for the length.
			tail = '{a: block_word(0), b: block_word(4),
				c: {block_buf[10], block_buf[9], block_buf[8], 8'd0}};
			for (int k = 0; k < LANES; k++) begin
				lane_words[k].c += byte_count;
				lane_words[k].a += tail.a;
				lane_words[k].b += tail.b;
				lane_words[k].c += tail.c;
				lane_words[k] = churn(lane_words[k]);
			end
			digest_queue.push_back('{high: lane_words[LANE_HIGH].c, low: lane_words[LANE_LOW].c});
			in_message = 1'b0;
		end
	endtask

	// Sender: offers queued beats, holding each one steady while stalled.
	// Gaps are mostly short with a few long ones, and now and then a calm
	// stretch with no gaps at all.
	byte_beat_t  beat_on_bus = '0;
	int unsigned send_gap    = 0;
	int unsigned send_calm   = 0;
	int unsigned send_roll;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid <= 1'b0;
			send_gap = 0;
		end else if (!item_valid || !item_stall) begin
			// Any beat on the bus was accepted at this edge.
			if (item_valid)
				absorb_beat(beat_on_bus);
			if (send_gap > 0) begin
				send_gap--;
				item_valid <= 1'b0;
			end else if (byte_beats.size() > 0) begin
				beat_on_bus = byte_beats.pop_front();
				data_byte  <= beat_on_bus.data;
				has_byte   <= beat_on_bus.has;
				last       <= beat_on_bus.fin;
				item_valid <= 1'b1;
				if (send_calm > 0) begin
					send_calm--;
					send_gap = 0;
				end else begin
					send_roll = $urandom_range(0, 99);
					if (send_roll < 3)
						send_calm = $urandom_range(20, 80);
					if (send_roll < 55)
						send_gap = 0;
					else if (send_roll < 92)
						send_gap = $urandom_range(1, 3);
					else
						send_gap = $urandom_range(8, 40);
				end
			end else begin
				item_valid <= 1'b0;
			end
		end
	end

	// Receiver: checks each accepted result beat against the oldest expected
	// digest, and stalls in random stretches, mostly brief.
	int unsigned stall_left = 0;
	int unsigned stall_roll;
	digest_t     want;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_stall <= 1'b0;
			stall_left = 0;
		end else begin
			if (result_valid && !result_stall) begin
				if (digest_queue.size() == 0) begin
					note_mismatch($sformatf("result %h/%h with nothing expected",
						hash_high, hash_low));
				end else begin
					want = digest_queue.pop_front();
					if (hash_high !== want.high)
						note_mismatch($sformatf("hash_high %h, expected %h",
							hash_high, want.high));
					if (hash_low !== want.low)
						note_mismatch($sformatf("hash_low %h, expected %h",
							hash_low, want.low));
				end
			end
			if (stall_left > 0) begin
				stall_left--;
			end else begin
				stall_roll = $urandom_range(0, 99);
				if (stall_roll < 65) begin
					result_stall <= 1'b0;
					stall_left = $urandom_range(0, 12);
				end else if (stall_roll < 95) begin
					result_stall <= 1'b1;
					stall_left = $urandom_range(0, 4);
				end else begin
					result_stall <= 1'b1;
					stall_left = $urandom_range(10, 40);
				end
			end
		end
	end

	// Watchdog: any accepted beat or register write counts as progress.
	int unsigned quiet_cycles = 0;

	always @(posedge clk) begin
		if (arst_n) begin
			if ((item_valid && !item_stall) || (result_valid && !result_stall) || cfg_write)
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("timeout: no progress for %0d cycles", WATCHDOG_LIMIT);
				$display("== FAIL ==");
				$finish;
			end
		end
	end

	task automatic queue_beat(input logic [7:0] d, input logic h, input logic f);
		byte_beats.push_back('{data: d, has: h, fin: f});
	endtask

	// Queues one message of n bytes, with the odd empty beat mixed in as
	// noise. With split_last the message ends on a beat of its own that
	// carries no byte; an empty message always ends that way.
	task automatic queue_message(input int unsigned n, input bit split_last);
		int unsigned pick;
		logic [7:0]  d;
		for (int unsigned i = 0; i < n; i++) begin
			if ($urandom_range(0, 9) == 0)
				queue_beat(8'($urandom_range(0, 255)), 1'b0, 1'b0);
			pick = $urandom_range(0, 9);
			d = (pick == 0) ? 8'h00 : (pick == 1) ? 8'hff : 8'($urandom_range(0, 255));
			queue_beat(d, 1'b1, (i == n - 1) && !split_last);
		end
		if (split_last || n == 0)
			queue_beat(8'($urandom_range(0, 255)), 1'b0, 1'b1);
	endtask

	// Random messages until about target message beats are queued. Lengths
	// are mostly short, with some near block boundaries and a few long ones.
	task automatic queue_random_messages(input int unsigned target);
		int unsigned counted;
		int unsigned n;
		int unsigned roll;
		bit          split;
		counted = 0;
		while (counted < target) begin
			roll = $urandom_range(0, 99);
			if (roll < 12)
				n = 12 * $urandom_range(1, 3) + $urandom_range(0, 2) - 1;
			else if (roll < 55)
				n = $urandom_range(0, 13);
			else if (roll < 85)
				n = $urandom_range(14, 40);
			else if (roll < 97)
				n = $urandom_range(41, 80);
			else
				n = $urandom_range(100, 200);
			split = (n == 0) || ($urandom_range(0, 1) == 1);
			queue_message(n, split);
			counted += n + split;
		end
	endtask

	// Waits until every queued beat has gone and every expected result has
	// arrived, then lets the pipeline settle.
	task automatic drain_pipeline();
		do
			@(posedge clk);
		while (byte_beats.size() != 0 || item_valid || digest_queue.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Register writes, made only while the block is idle. The predictor's
	// copy of a seed changes with the write itself.
	task automatic apply_seeds(input bit wr_high, input logic [31:0] high_val,
		input bit wr_low, input logic [31:0] low_val);
		if (wr_high) begin
			@(posedge clk);
			cfg_write <= 1'b1;
			cfg_index <= REG_SEED_HIGH;
			cfg_data  <= high_val;
			seed_high_reg = high_val;
		end
		if (wr_low) begin
			@(posedge clk);
			cfg_write <= 1'b1;
			cfg_index <= REG_SEED_LOW;
			cfg_data  <= low_val;
			seed_low_reg = low_val;
		end
		@(posedge clk);
		cfg_write <= 1'b0;
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part, with the seeds at their reset values. The empty
		// message comes first.
		queue_beat(8'h3c, 1'b0, 1'b1);
		// An empty beat does nothing; then a single byte that also ends
		// its message.
		queue_beat(8'hff, 1'b0, 1'b0);
		queue_beat(8'hff, 1'b1, 1'b1);
		// A full block whose final byte carries last: the block is mixed
		// before the message is finished with no tail.
		for (int i = 0; i < 11; i++)
			queue_beat((i % 2 == 0) ? 8'hff : 8'h00, 1'b1, 1'b0);
		queue_beat(8'h80, 1'b1, 1'b1);
		// A byte, then last on a beat of its own whose data is ignored.
		queue_beat(8'h00, 1'b1, 1'b0);
		queue_beat(8'h5a, 1'b0, 1'b1);
		drain_pipeline();

		// Random phases under a range of seed settings, extremes included,
		// with the sender held off until the block is idle between them.
		apply_seeds(1'b1, 32'hffffffff, 1'b1, 32'hffffffff);
		queue_random_messages(350);
		drain_pipeline();

		apply_seeds(1'b1, 32'h00000000, 1'b1, 32'h00000000);
		queue_random_messages(350);
		drain_pipeline();

		apply_seeds(1'b1, $urandom, 1'b0, 32'd0);
		queue_random_messages(350);
		drain_pipeline();

		apply_seeds(1'b1, $urandom, 1'b1, $urandom);
		queue_random_messages(350);
		drain_pipeline();

		apply_seeds(1'b1, 32'h00000000, 1'b1, 32'hffffffff);
		queue_random_messages(350);
		drain_pipeline();

		if (digest_queue.size() != 0)
			note_mismatch($sformatf("%0d expected results never arrived",
				digest_queue.size()));
		if (mismatches == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
